// ===== sv/cisv_pkg.sv =====
// Package with beat types and character constants for the correlation id validator.
package cisv_pkg;

   // Request beat: one character of the identifier string
   typedef struct packed {
      logic [7:0] character;
      logic       is_last;
   } req_beat_type;

   // Response beat: verdict for one complete string
   typedef struct packed {
      logic        valid_res;
      logic        version;
      logic [31:0] element_value;
      logic [6:0]  prefix_length;
   } rsp_beat_type;

   // Character classification passed from the classifier to the scanner
   typedef struct packed {
      logic       is_dot;
      logic       is_b64;
      logic       is_digit;
      logic [3:0] digit;
   } char_class_type;

   // Character codes
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

   // Base group lengths and limits
   localparam logic [4:0] V1_BASE_LEN   = 5'd16;
   localparam logic [4:0] V2_BASE_LEN   = 5'd22;
   localparam logic [7:0] V1_LIMIT      = 8'd63;
   localparam logic [3:0] MAX_DIGITS    = 4'd10;

   // Saturation points of the counters
   localparam logic [7:0] TOTAL_SAT     = 8'd255;
   localparam logic [4:0] FIRST_SAT     = 5'd31;
   localparam logic [3:0] GROUP_SAT     = 4'd15;
   localparam logic [6:0] PREFIX_SAT    = 7'd127;

   // Accumulator value once the element overflows 32 bits
   localparam logic [32:0] ACC_CLIP     = 33'h1_0000_0000;

endpackage

// ===== sv/cisv_char_class.sv =====
// Character classifier: dot, base64 and decimal digit decode.
module cisv_char_class (
   input  logic [7:0]               character,
   output cisv_pkg::char_class_type char_class
);

   // Set membership checks on the byte
   always_comb begin
      char_class.is_dot   = (character == cisv_pkg::CHAR_DOT);
      char_class.is_digit = (character inside {[cisv_pkg::CHAR_ZERO:cisv_pkg::CHAR_NINE]});
      char_class.is_b64   = (character inside {
                               [cisv_pkg::CHAR_UPPER_A:cisv_pkg::CHAR_UPPER_Z],
                               [cisv_pkg::CHAR_LOWER_A:cisv_pkg::CHAR_LOWER_Z],
                               [cisv_pkg::CHAR_ZERO:cisv_pkg::CHAR_NINE],
                               cisv_pkg::CHAR_PLUS,
                               cisv_pkg::CHAR_SLASH});
      // low nibble of '0'..'9' is the digit value
      char_class.digit    = character[3:0];
   end

endmodule

// ===== sv/cisv_scan.sv =====
// String scanner: per-string counters, element accumulator and final verdict.
module cisv_scan #(
   parameter int MAX_TEXT_LENGTH = 127
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     is_last,
   input  cisv_pkg::char_class_type char_class,
   output cisv_pkg::rsp_beat_type   result
);

   localparam logic [7:0] V2_LIMIT = 8'(MAX_TEXT_LENGTH);

   logic [7:0]  total_count_ff, total_count_in;
   logic        past_first_ff, past_first_in;
   logic [4:0]  first_len_ff, first_len_in;
   logic [3:0]  group_len_ff, group_len_in;
   logic [32:0] acc_ff, acc_in;
   logic [6:0]  last_dot_ff, last_dot_in;
   logic        error_ff, error_in;

   logic [6:0]  total_sat7;
   logic [35:0] acc_times_ten;
   logic        ok;
   logic [7:0]  limit;

   // Previous count clipped to the prefix width
   assign total_sat7 = (total_count_ff > 8'(cisv_pkg::PREFIX_SAT)) ?
                       cisv_pkg::PREFIX_SAT : total_count_ff[6:0];

   // acc * 10 + digit as two shifted copies and a digit add
   assign acc_times_ten = {1'b0, acc_ff[31:0], 3'b000} + {3'b000, acc_ff[31:0], 1'b0}
                        + {32'd0, char_class.digit};

   // Next state for this character
   always_comb begin
      total_count_in = total_count_ff;
      past_first_in  = past_first_ff;
      first_len_in   = first_len_ff;
      group_len_in   = group_len_ff;
      acc_in         = acc_ff;
      last_dot_in    = last_dot_ff;
      error_in       = error_ff;
      if (char_class.is_dot) begin
         if (past_first_ff && group_len_ff == 4'd0) error_in = 1'b1;
         past_first_in = 1'b1;
         last_dot_in   = total_sat7;
         group_len_in  = 4'd0;
         acc_in        = '0;
      end else if (!past_first_ff) begin
         if (!char_class.is_b64) error_in = 1'b1;
         if (first_len_ff < cisv_pkg::FIRST_SAT) first_len_in = first_len_ff + 5'd1;
      end else begin
         if (char_class.is_digit) begin
            if (acc_ff[32] || acc_times_ten[35:32] != 4'd0) begin
               acc_in = cisv_pkg::ACC_CLIP;
            end else begin
               acc_in = {1'b0, acc_times_ten[31:0]};
            end
         end else begin
            error_in = 1'b1;
         end
         if (group_len_ff < cisv_pkg::GROUP_SAT) group_len_in = group_len_ff + 4'd1;
      end
      if (total_count_ff < cisv_pkg::TOTAL_SAT) total_count_in = total_count_ff + 8'd1;
   end

   // Verdict from the state after this character
   always_comb begin
      ok    = !error_in;
      limit = 8'd0;
      if (first_len_in == cisv_pkg::V1_BASE_LEN) begin
         limit = cisv_pkg::V1_LIMIT;
      end else if (first_len_in == cisv_pkg::V2_BASE_LEN) begin
         limit = V2_LIMIT;
      end else begin
         ok = 1'b0;
      end
      if (total_count_in > limit) ok = 1'b0;

      result.element_value = 32'd0;
      if (past_first_in) begin
         if (group_len_in == 4'd0 || group_len_in > cisv_pkg::MAX_DIGITS || acc_in[32]) begin
            ok = 1'b0;
         end
         if (!acc_in[32]) result.element_value = acc_in[31:0];
         result.prefix_length = last_dot_in;
      end else begin
         result.prefix_length = (total_count_in > 8'(cisv_pkg::PREFIX_SAT)) ?
                                cisv_pkg::PREFIX_SAT : total_count_in[6:0];
      end
      result.valid_res = ok;
      result.version   = (first_len_in == cisv_pkg::V2_BASE_LEN);
   end

   // State registers, cleared after the last character of each string
   always_ff @(posedge clock) begin
      if (reset || (step && is_last)) begin
         total_count_ff <= '0;
         past_first_ff  <= 1'b0;
         first_len_ff   <= '0;
         group_len_ff   <= '0;
         acc_ff         <= '0;
         last_dot_ff    <= '0;
         error_ff       <= 1'b0;
      end else if (step) begin
         total_count_ff <= total_count_in;
         past_first_ff  <= past_first_in;
         first_len_ff   <= first_len_in;
         group_len_ff   <= group_len_in;
         acc_ff         <= acc_in;
         last_dot_ff    <= last_dot_in;
         error_ff       <= error_in;
      end
   end

endmodule

// ===== sv/correlation_id_string_validator.sv =====
// Top level of the correlation id string validator: beat registers and scanner.
// Takes one character per cycle while req_stall is low and gives one result beat
// on each character flagged is_last: the input register feeds the scanner, and
// its verdict is loaded into the result register as that character leaves the
// input register. Characters that do not end a string flow through without a
// result. A waiting result only holds back a string-ending character; req_stall
// follows rsp_stall in the same cycle when such a character sits behind a held
// result. No clearing pass after reset.
module correlation_id_string_validator #(
   parameter int MAX_TEXT_LENGTH = 127
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cisv_pkg::req_beat_type req_beat,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cisv_pkg::rsp_beat_type rsp_beat
);

   logic                     in_valid_ff;
   cisv_pkg::req_beat_type   in_beat_ff;
   logic                     rsp_valid_ff;
   cisv_pkg::rsp_beat_type   rsp_beat_ff;
   logic                     out_free;
   logic                     step;
   logic                     accept;
   cisv_pkg::char_class_type char_class;
   cisv_pkg::rsp_beat_type   result;

   // Flow control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && (!in_beat_ff.is_last || out_free);
   assign req_stall = in_valid_ff && !step;
   assign accept    = req_valid && !req_stall;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) in_beat_ff <= req_beat;
   end

   cisv_char_class u_class (
      .character  (in_beat_ff.character),
      .char_class (char_class)
   );

   cisv_scan #(
      .MAX_TEXT_LENGTH (MAX_TEXT_LENGTH)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .is_last    (in_beat_ff.is_last),
      .char_class (char_class),
      .result     (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && in_beat_ff.is_last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_beat_ff.is_last) rsp_beat_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   // A new result only appears after a string-ending character left the input register
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff && in_beat_ff.is_last))
      else $error("result raised without a string-ending character");

   // Input side stalls only with a full input register
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("stall without a held character");

   // A passing version 0 string is at most 63 characters long, so its prefix length stays below 64
   a_v1_prefix: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_beat_ff.valid_res && !rsp_beat_ff.version)
         |-> (rsp_beat_ff.prefix_length[6] == 1'b0))
      else $error("version 0 prefix beyond its limit");

endmodule
